// File: sv/alcr_pkg.sv
// ----------------------------------------------------------------------------
// alcr_pkg
// Shared constants, types and controller/datapath interface structs for the
// fully associative lookup cache with clock replacement.
// ----------------------------------------------------------------------------
package alcr_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int KEY_W   = 32;
	localparam int IN_W    = 32;
	localparam int VAL_W   = 32;
	localparam int SLOT_W  = 6;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_FILL   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENC,
		ST_SWEEP,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // latch the incoming word
		logic compare;  // register the parallel key match
		logic resolve;  // pick lowest match, mark used, read value
		logic sweep;    // clear used bit under pointer and advance
		logic write;    // write entry under pointer
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic ptr_used;
	} status_t;

endpackage

// File: sv/alcr_ctrl.sv
// ----------------------------------------------------------------------------
// alcr_ctrl
// Sequencer for lookups (match, resolve, result) and fills (clock sweep,
// write, result).
// ----------------------------------------------------------------------------
module alcr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              operation,
	input  alcr_pkg::status_t status,
	output logic              busy,
	output logic              done,
	output alcr_pkg::cmd_t    cmd
);

	alcr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alcr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			alcr_pkg::ST_IDLE, alcr_pkg::ST_DONE: begin
				// the result cycle also takes the next word
				busy    = 1'b0;
				done    = (state_q == alcr_pkg::ST_DONE);
				state_d = alcr_pkg::ST_IDLE;
				if (start) begin
					cmd.load = 1'b1;
					if (operation == alcr_pkg::OP_FILL) begin
						state_d = alcr_pkg::ST_SWEEP;
					end else begin
						cmd.compare = 1'b1;
						state_d     = alcr_pkg::ST_ENC;
					end
				end
			end
			alcr_pkg::ST_ENC: begin
				cmd.resolve = 1'b1;
				state_d     = alcr_pkg::ST_DONE;
			end
			alcr_pkg::ST_SWEEP: begin
				if (status.ptr_used) begin
					cmd.sweep = 1'b1;
				end else begin
					cmd.write = 1'b1;
					state_d   = alcr_pkg::ST_DONE;
				end
			end
			default: begin
				state_d = alcr_pkg::ST_IDLE;
			end
		endcase
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held for two cycles");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not make unit busy");

endmodule

// File: sv/alcr_dp.sv
// ----------------------------------------------------------------------------
// alcr_dp
// Entry store, parallel key match, priority pick, used/valid bits, clock
// pointer and value memory.
// ----------------------------------------------------------------------------
module alcr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  alcr_pkg::cmd_t                cmd,
	input  logic [alcr_pkg::IN_W-1:0]     table_key,
	input  logic [alcr_pkg::IN_W-1:0]     symbol_key,
	input  logic [alcr_pkg::VAL_W-1:0]    fill_value,
	output alcr_pkg::status_t             status,
	output logic                          hit,
	output logic [alcr_pkg::VAL_W-1:0]    found_value,
	output logic [alcr_pkg::SLOT_W-1:0]   slot
);

	logic [alcr_pkg::KEY_W-1:0] tkey_q [alcr_pkg::ENTRIES];
	logic [alcr_pkg::KEY_W-1:0] skey_q [alcr_pkg::ENTRIES];
	logic [alcr_pkg::VAL_W-1:0] value_mem [alcr_pkg::ENTRIES];

	logic [alcr_pkg::ENTRIES-1:0] used_q;
	logic [alcr_pkg::ENTRIES-1:0] valid_q;
	logic [alcr_pkg::IDX_W-1:0]   ptr_q;
	logic [alcr_pkg::IDX_W-1:0]   ptr_next;

	logic [alcr_pkg::KEY_W-1:0]   tkey_in_q;
	logic [alcr_pkg::KEY_W-1:0]   skey_in_q;
	logic [alcr_pkg::VAL_W-1:0]   val_in_q;

	logic [alcr_pkg::KEY_W-1:0]   tkey_cmp;
	logic [alcr_pkg::KEY_W-1:0]   skey_cmp;
	logic [alcr_pkg::ENTRIES-1:0] match_now;
	logic [alcr_pkg::ENTRIES-1:0] match_s1;
	logic [alcr_pkg::IDX_W-1:0]   enc_idx;
	logic                         enc_hit;

	logic                         hit_q;
	logic [alcr_pkg::IDX_W-1:0]   slot_q;
	logic [alcr_pkg::VAL_W-1:0]   rd_q;

	assign tkey_cmp = alcr_pkg::KEY_W'(table_key);
	assign skey_cmp = alcr_pkg::KEY_W'(symbol_key);

	always_comb begin
		for (int i = 0; i < alcr_pkg::ENTRIES; i++) begin
			match_now[i] = valid_q[i] && (tkey_q[i] == tkey_cmp) && (skey_q[i] == skey_cmp);
		end
	end

	// lowest index wins
	always_comb begin
		enc_idx = '0;
		enc_hit = |match_s1;
		for (int i = alcr_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				enc_idx = alcr_pkg::IDX_W'(i);
			end
		end
	end

	assign ptr_next = (ptr_q == alcr_pkg::IDX_W'(alcr_pkg::ENTRIES - 1)) ?
		'0 : ptr_q + 1'b1;

	assign status.ptr_used = used_q[ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			valid_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.resolve && enc_hit) begin
				used_q[enc_idx] <= 1'b1;
			end
			if (cmd.sweep) begin
				used_q[ptr_q] <= 1'b0;
				ptr_q         <= ptr_next;
			end
			if (cmd.write) begin
				used_q[ptr_q]  <= 1'b1;
				valid_q[ptr_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tkey_in_q <= tkey_cmp;
			skey_in_q <= skey_cmp;
			val_in_q  <= fill_value;
		end
		if (cmd.compare) begin
			match_s1 <= match_now;
		end
		if (cmd.write) begin
			tkey_q[ptr_q] <= tkey_in_q;
			skey_q[ptr_q] <= skey_in_q;
			hit_q         <= 1'b0;
			slot_q        <= ptr_q;
		end
		if (cmd.resolve) begin
			hit_q  <= enc_hit;
			slot_q <= enc_hit ? enc_idx : '0;
		end
	end

	// value store
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			value_mem[ptr_q] <= val_in_q;
		end
		if (cmd.resolve) begin
			rd_q <= value_mem[enc_idx];
		end
	end

	assign hit         = hit_q;
	assign found_value = hit_q ? rd_q : '0;
	assign slot        = alcr_pkg::SLOT_W'(slot_q);

	a_sweep_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |=> !used_q[$past(ptr_q)]) else $error("sweep left used bit set");

	a_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |=> valid_q[$past(ptr_q)] && used_q[$past(ptr_q)] && ptr_q == $past(ptr_q))
		else $error("fill did not mark entry or moved pointer");

	a_hit_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resolve && enc_hit |=> hit_q && used_q[slot_q] && valid_q[slot_q])
		else $error("hit on entry not marked used and valid");

endmodule

// File: sv/assoc_lookup_cache_clock_replace_unit.sv
// ----------------------------------------------------------------------------
// assoc_lookup_cache_clock_replace_unit
// Lookup: the key match is registered, then resolved into the result; busy until then.
// Fill: the clock sweep clears k used entries, then the entry is written and shown;
// k = 0 to 64, one per cycle through the pointer's single used-bit read.
// The unit takes the next word in the cycle its result is shown.
// Reset clears valid and used bits and the pointer; no clearing pass.
// ----------------------------------------------------------------------------
module assoc_lookup_cache_clock_replace_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [alcr_pkg::IN_W-1:0]   table_key,
	input  logic [alcr_pkg::IN_W-1:0]   symbol_key,
	input  logic [alcr_pkg::VAL_W-1:0]  fill_value,
	output logic                        done,
	output logic                        hit,
	output logic [alcr_pkg::VAL_W-1:0]  found_value,
	output logic [alcr_pkg::SLOT_W-1:0] slot
);

	alcr_pkg::cmd_t    cmd;
	alcr_pkg::status_t status;

	alcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.status    (status),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd)
	);

	alcr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.table_key   (table_key),
		.symbol_key  (symbol_key),
		.fill_value  (fill_value),
		.status      (status),
		.hit         (hit),
		.found_value (found_value),
		.slot        (slot)
	);

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the associative lookup cache with clock replacement. A directed
// table covers the extreme keys, duplicate fills and near misses. Random
// lookups and fills follow, drawn from a small key pool so that hits are
// common. One scripted sequence marks every entry used so that a fill must
// sweep a whole turn. Each result is compared against a shadow copy of the
// cache updated as each word is accepted, or to the table for typed rows.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int TAIL_CYCLES   = 80;
	localparam int POOL_SIZE     = 48;
	localparam int RANDOM_WORDS  = 185;
	localparam int REPORT_LIMIT  = 10;
	localparam logic [15:0] FRESH_TAG = 16'hC10C;

	typedef struct packed {
		logic                         hit;
		logic [alcr_pkg::VAL_W-1:0]   value;
		logic [alcr_pkg::SLOT_W-1:0]  slot;
	} cache_result_t;

	typedef struct packed {
		logic                         typed;
		logic                         op;
		logic [alcr_pkg::IN_W-1:0]    tkey;
		logic [alcr_pkg::IN_W-1:0]    skey;
		logic [alcr_pkg::VAL_W-1:0]   fval;
		cache_result_t                want;
	} stim_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         operation = alcr_pkg::OP_LOOKUP;
	logic [alcr_pkg::IN_W-1:0]    table_key = '0;
	logic [alcr_pkg::IN_W-1:0]    symbol_key = '0;
	logic [alcr_pkg::VAL_W-1:0]   fill_value = '0;
	logic                         busy;
	logic                         done;
	logic                         hit;
	logic [alcr_pkg::VAL_W-1:0]   found_value;
	logic [alcr_pkg::SLOT_W-1:0]  slot;

	// shadow copy of the cache
	logic [alcr_pkg::KEY_W-1:0]   shadow_tkey [alcr_pkg::ENTRIES];
	logic [alcr_pkg::KEY_W-1:0]   shadow_skey [alcr_pkg::ENTRIES];
	logic [alcr_pkg::VAL_W-1:0]   shadow_value [alcr_pkg::ENTRIES];
	bit                           shadow_used [alcr_pkg::ENTRIES];
	bit                           shadow_valid [alcr_pkg::ENTRIES];
	int                           shadow_hand;

	cache_result_t                expected_results [$];
	cache_result_t                oldest;
	stim_row_t                    directed_rows [$];
	logic [alcr_pkg::IN_W-1:0]    pool_tkey [POOL_SIZE];
	logic [alcr_pkg::IN_W-1:0]    pool_skey [POOL_SIZE];

	int idle_pct;
	int cycle_count;
	int mismatches;
	int words_sent;
	int lookups;
	int hits;
	int fills;
	int longest_sweep;
	int full_turns;
	int drains;

	assoc_lookup_cache_clock_replace_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.table_key   (table_key),
		.symbol_key  (symbol_key),
		.fill_value  (fill_value),
		.done        (done),
		.hit         (hit),
		.found_value (found_value),
		.slot        (slot)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Applies one word to the shadow cache and returns what the unit should show.
	function automatic cache_result_t cache_access(input logic op,
			input logic [alcr_pkg::IN_W-1:0] tk, input logic [alcr_pkg::IN_W-1:0] sk,
			input logic [alcr_pkg::VAL_W-1:0] fv);
		cache_result_t r;
		int i;
		int sweep;
		r = '0;
		sweep = 0;
		if (op == alcr_pkg::OP_LOOKUP) begin
			lookups++;
			for (i = 0; i < alcr_pkg::ENTRIES; i++) begin
				if (shadow_valid[i] && shadow_tkey[i] == tk[alcr_pkg::KEY_W-1:0] &&
						shadow_skey[i] == sk[alcr_pkg::KEY_W-1:0]) begin
					shadow_used[i] = 1'b1;
					r.hit = 1'b1;
					r.value = shadow_value[i];
					r.slot = alcr_pkg::SLOT_W'(i);
					break;
				end
			end
			if (r.hit)
				hits++;
		end else begin
			fills++;
			while (shadow_used[shadow_hand] && sweep <= alcr_pkg::ENTRIES) begin
				shadow_used[shadow_hand] = 1'b0;
				shadow_hand = (shadow_hand == alcr_pkg::ENTRIES - 1) ? 0 : shadow_hand + 1;
				sweep++;
			end
			if (sweep > longest_sweep)
				longest_sweep = sweep;
			if (sweep >= alcr_pkg::ENTRIES)
				full_turns++;
			shadow_tkey[shadow_hand] = tk[alcr_pkg::KEY_W-1:0];
			shadow_skey[shadow_hand] = sk[alcr_pkg::KEY_W-1:0];
			shadow_value[shadow_hand] = fv;
			shadow_used[shadow_hand] = 1'b1;
			shadow_valid[shadow_hand] = 1'b1;
			r.slot = alcr_pkg::SLOT_W'(shadow_hand);
		end
		return r;
	endfunction

	function automatic bit all_entries_fresh();
		int i;
		for (i = 0; i < alcr_pkg::ENTRIES; i++)
			if (!shadow_valid[i] ||
					shadow_tkey[i][alcr_pkg::KEY_W-1:alcr_pkg::KEY_W-16] != FRESH_TAG)
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic add_row(input logic typed, input logic op,
			input logic [alcr_pkg::IN_W-1:0] tk, input logic [alcr_pkg::IN_W-1:0] sk,
			input logic [alcr_pkg::VAL_W-1:0] fv, input logic h,
			input logic [alcr_pkg::VAL_W-1:0] v, input logic [alcr_pkg::SLOT_W-1:0] s);
		stim_row_t row;
		row.typed = typed;
		row.op = op;
		row.tkey = tk;
		row.skey = sk;
		row.fval = fv;
		row.want.hit = h;
		row.want.value = v;
		row.want.slot = s;
		directed_rows.push_back(row);
	endtask

	// Holds the word on the ports until the unit takes it.
	task automatic issue_word(input logic op, input logic [alcr_pkg::IN_W-1:0] tk,
			input logic [alcr_pkg::IN_W-1:0] sk, input logic [alcr_pkg::VAL_W-1:0] fv,
			input logic typed, input cache_result_t want);
		cache_result_t predicted;
		start <= 1'b1;
		operation <= op;
		table_key <= tk;
		symbol_key <= sk;
		fill_value <= fv;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = cache_access(op, tk, sk, fv);
		expected_results.push_back(typed ? want : predicted);
		words_sent++;
	endtask

	task automatic idle_gap();
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		drains++;
	endtask

	task automatic random_word();
		logic op;
		logic [alcr_pkg::IN_W-1:0] tk;
		logic [alcr_pkg::IN_W-1:0] sk;
		logic [alcr_pkg::VAL_W-1:0] fv;
		int k;
		int r;
		op = ($urandom_range(0, 99) < 35) ? alcr_pkg::OP_FILL : alcr_pkg::OP_LOOKUP;
		k = $urandom_range(0, POOL_SIZE - 1);
		r = $urandom_range(0, 99);
		tk = pool_tkey[k];
		sk = pool_skey[k];
		if (r >= 90) begin
			tk = $urandom;
			sk = $urandom;
		end else if (r >= 85) begin
			tk[$urandom_range(0, alcr_pkg::IN_W - 1)] ^= 1'b1;
		end else if (r >= 80) begin
			sk[$urandom_range(0, alcr_pkg::IN_W - 1)] ^= 1'b1;
		end
		case ($urandom_range(0, 9))
			0: fv = '0;
			1: fv = '1;
			default: fv = $urandom;
		endcase
		idle_gap();
		issue_word(op, tk, sk, fv, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("testbench failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (done === 1'b1) begin
			if (expected_results.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("cycle %0d: result word with none outstanding", cycle_count);
				mismatches++;
			end else begin
				oldest = expected_results.pop_front();
				if (hit !== oldest.hit || found_value !== oldest.value ||
						slot !== oldest.slot) begin
					if (mismatches < REPORT_LIMIT)
						$display("cycle %0d: expected hit %0b value %h slot %0d, got hit %0b value %h slot %0d",
							cycle_count, oldest.hit, oldest.value, oldest.slot,
							hit, found_value, slot);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int i;
		int p;
		int n;
		stim_row_t row;

		for (i = 0; i < alcr_pkg::ENTRIES; i++) begin
			shadow_tkey[i] = '0;
			shadow_skey[i] = '0;
			shadow_value[i] = '0;
			shadow_used[i] = 1'b0;
			shadow_valid[i] = 1'b0;
		end
		shadow_hand = 0;
		pool_tkey[0] = '0;           pool_skey[0] = '0;
		pool_tkey[1] = '1;           pool_skey[1] = '1;
		pool_tkey[2] = '0;           pool_skey[2] = '1;
		pool_tkey[3] = 32'h80000000; pool_skey[3] = 32'h00000001;
		for (i = 4; i < POOL_SIZE; i++) begin
			pool_tkey[i] = $urandom;
			pool_skey[i] = (i % 4 == 0) ? pool_skey[i - 1] : $urandom;
		end

		// after reset a zero key pair must miss; the rest follows the hand
		add_row(1'b1, alcr_pkg::OP_LOOKUP, 32'h00000000, 32'h00000000, 32'h00000000,
			1'b0, 32'h0, 6'd0);
		add_row(1'b1, alcr_pkg::OP_FILL,   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			1'b0, 32'h0, 6'd0);
		add_row(1'b1, alcr_pkg::OP_LOOKUP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000,
			1'b1, 32'hFFFFFFFF, 6'd0);
		add_row(1'b1, alcr_pkg::OP_FILL,   32'h00000000, 32'h00000000, 32'h00000000,
			1'b0, 32'h0, 6'd1);
		add_row(1'b1, alcr_pkg::OP_LOOKUP, 32'h00000000, 32'h00000000, 32'hFFFFFFFF,
			1'b1, 32'h0, 6'd1);
		// duplicate key pair lands in the next slot, lookups keep the lower one
		add_row(1'b1, alcr_pkg::OP_FILL,   32'h00000000, 32'h00000000, 32'h5A5A5A5A,
			1'b0, 32'h0, 6'd2);
		add_row(1'b1, alcr_pkg::OP_LOOKUP, 32'h00000000, 32'h00000000, 32'h00000000,
			1'b1, 32'h0, 6'd1);
		add_row(1'b1, alcr_pkg::OP_LOOKUP, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
			1'b0, 32'h0, 6'd0);
		add_row(1'b1, alcr_pkg::OP_LOOKUP, 32'h00000000, 32'hFFFFFFFF, 32'h00000000,
			1'b0, 32'h0, 6'd0);
		add_row(1'b0, alcr_pkg::OP_FILL,   32'h80000000, 32'h00000001, 32'h80000001,
			1'b0, 32'h0, 6'd0);
		add_row(1'b0, alcr_pkg::OP_LOOKUP, 32'h80000000, 32'h00000001, 32'h00000000,
			1'b0, 32'h0, 6'd0);
		add_row(1'b0, alcr_pkg::OP_LOOKUP, 32'h00000001, 32'h80000000, 32'h00000000,
			1'b0, 32'h0, 6'd0);
		add_row(1'b0, alcr_pkg::OP_FILL,   32'h7FFFFFFF, 32'hFFFFFFFE, 32'h00000001,
			1'b0, 32'h0, 6'd0);
		add_row(1'b0, alcr_pkg::OP_LOOKUP, 32'h7FFFFFFF, 32'hFFFFFFFE, 32'hAAAAAAAA,
			1'b0, 32'h0, 6'd0);
		add_row(1'b0, alcr_pkg::OP_LOOKUP, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h55555555,
			1'b0, 32'h0, 6'd0);
		add_row(1'b0, alcr_pkg::OP_FILL,   32'h13579BDF, 32'h2468ACE0, 32'hFEDCBA98,
			1'b0, 32'h0, 6'd0);
		add_row(1'b0, alcr_pkg::OP_LOOKUP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000,
			1'b0, 32'h0, 6'd0);
		add_row(1'b0, alcr_pkg::OP_LOOKUP, 32'h13579BDF, 32'h2468ACE0, 32'h00000000,
			1'b0, 32'h0, 6'd0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 14;
		for (i = 0; i < directed_rows.size(); i++) begin
			row = directed_rows[i];
			idle_gap();
			issue_word(row.op, row.tkey, row.skey, row.fval, row.typed, row.want);
		end

		for (p = 0; p < 3; p++) begin
			idle_pct = (p == 0) ? 14 : (p == 1) ? 66 : 0;
			if (p == 1) begin
				// fresh keys everywhere, then hit each one so every used bit is set
				n = 0;
				while (!all_entries_fresh() && n < 4 * alcr_pkg::ENTRIES) begin
					idle_gap();
					issue_word(alcr_pkg::OP_FILL, {FRESH_TAG, n[15:0]},
						~{FRESH_TAG, n[15:0]}, $urandom, 1'b0, '0);
					n++;
				end
				for (i = 0; i < alcr_pkg::ENTRIES; i++) begin
					idle_gap();
					issue_word(alcr_pkg::OP_LOOKUP, shadow_tkey[i], shadow_skey[i],
						$urandom, 1'b0, '0);
				end
				idle_gap();
				issue_word(alcr_pkg::OP_FILL, $urandom, $urandom, $urandom, 1'b0, '0);
			end
			for (i = 0; i < RANDOM_WORDS; i++)
				random_word();
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d words sent: %0d lookups with %0d hits, %0d fills", words_sent,
			lookups, hits, fills);
		$display("longest clock sweep %0d entries, %0d full-turn sweeps, %0d drains, %0d mismatches",
			longest_sweep, full_turns, drains, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
